@@ src/absum_pkg.sv @@
// ----------------------------------------------------------------------------
// absum_pkg
// Types, codes and constants shared by the A/B boot slot update manager.
// ----------------------------------------------------------------------------
package absum_pkg;

  localparam int unsigned SlotWidth     = 8;
  localparam int unsigned VersionWidth  = 32;
  localparam int unsigned AttemptWidth  = 8;

  localparam logic [AttemptWidth-1:0] MaxBootAttemptsReset = AttemptWidth'(3);

  typedef enum logic [1:0] {
    ModeStage   = 2'd0,
    ModeBoot    = 2'd1,
    ModeConfirm = 2'd2,
    ModeRestore = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StatusOk         = 3'd0,
    StatusInvalid    = 3'd1,
    StatusInProgress = 3'd2,
    StatusVersion    = 3'd3,
    StatusNoCand     = 3'd4
  } status_e;

  typedef struct packed {
    mode_e                   mode;
    logic [SlotWidth-1:0]    slot;
    logic [VersionWidth-1:0] version;
    logic [VersionWidth-1:0] floor_version;
  } item_t;

  typedef struct packed {
    logic                    live_slot;
    logic [VersionWidth-1:0] live_version;
    logic [VersionWidth-1:0] floor_version;
    logic                    pending;
    logic                    cand_slot;
    logic [VersionWidth-1:0] cand_version;
    logic [AttemptWidth-1:0] attempts;
  } meta_t;

  typedef struct packed {
    status_e status;
    logic    rollback;
    meta_t   meta;
  } result_t;

endpackage

@@ src/absum_in_reg.sv @@
// ----------------------------------------------------------------------------
// absum_in_reg
// Input register: holds one request until the evaluation stage takes it.
// ----------------------------------------------------------------------------
module absum_in_reg
  import absum_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  advance_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

@@ src/absum_meta_core.sv @@
// ----------------------------------------------------------------------------
// absum_meta_core
// Slot metadata registers and command evaluation.
// ----------------------------------------------------------------------------
module absum_meta_core
  import absum_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [AttemptWidth-1:0] cfg_wdata_i,
  input  logic                    advance_i,
  input  item_t                   item_i,
  output result_t                 result_o
);

  logic [AttemptWidth-1:0] max_attempts_q;
  meta_t                   meta_q;
  meta_t                   meta_d;
  status_e                 status;
  logic                    rollback;
  logic                    slot_bad;
  logic [AttemptWidth:0]   attempts_inc;

  assign slot_bad     = item_i.slot > SlotWidth'(1);
  assign attempts_inc = {1'b0, meta_q.attempts} + (AttemptWidth+1)'(1);

  always_comb begin
    meta_d   = meta_q;
    status   = StatusOk;
    rollback = 1'b0;
    unique case (item_i.mode)
      ModeStage: begin
        if (slot_bad || item_i.slot == SlotWidth'(meta_q.live_slot) ||
            item_i.version == '0) begin
          status = StatusInvalid;
        end else if (meta_q.pending) begin
          status = StatusInProgress;
        end else if (item_i.version < meta_q.floor_version) begin
          status = StatusVersion;
        end else begin
          meta_d.pending      = 1'b1;
          meta_d.cand_slot    = item_i.slot[0];
          meta_d.cand_version = item_i.version;
          meta_d.attempts     = '0;
        end
      end
      ModeBoot: begin
        if (max_attempts_q == '0) begin
          status = StatusInvalid;
        end else if (!meta_q.pending) begin
          status = StatusNoCand;
        end else if (attempts_inc >= {1'b0, max_attempts_q}) begin
          rollback            = 1'b1;
          meta_d.pending      = 1'b0;
          meta_d.cand_slot    = 1'b0;
          meta_d.cand_version = '0;
          meta_d.attempts     = '0;
        end else begin
          meta_d.attempts = attempts_inc[AttemptWidth-1:0];
        end
      end
      ModeConfirm: begin
        if (!meta_q.pending || item_i.slot != SlotWidth'(meta_q.cand_slot)) begin
          status = StatusInvalid;
        end else if (item_i.version != meta_q.cand_version) begin
          status = StatusVersion;
        end else begin
          meta_d.live_slot    = meta_q.cand_slot;
          meta_d.live_version = meta_q.cand_version;
          if (meta_q.floor_version < meta_q.cand_version) begin
            meta_d.floor_version = meta_q.cand_version;
          end
          meta_d.pending      = 1'b0;
          meta_d.cand_slot    = 1'b0;
          meta_d.cand_version = '0;
          meta_d.attempts     = '0;
        end
      end
      ModeRestore: begin
        if (slot_bad || item_i.version < item_i.floor_version) begin
          status = StatusInvalid;
        end else begin
          meta_d.live_slot     = item_i.slot[0];
          meta_d.live_version  = item_i.version;
          meta_d.floor_version = item_i.floor_version;
          meta_d.pending       = 1'b0;
          meta_d.cand_slot     = 1'b0;
          meta_d.cand_version  = '0;
          meta_d.attempts      = '0;
        end
      end
      default: begin
        status = StatusInvalid;
      end
    endcase
  end

  assign result_o.status   = status;
  assign result_o.rollback = rollback;
  assign result_o.meta     = meta_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_attempts_q <= MaxBootAttemptsReset;
    end else if (cfg_we_i) begin
      max_attempts_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (advance_i) begin
      meta_q <= meta_d;
    end
  end

endmodule

@@ src/absum_out_reg.sv @@
// ----------------------------------------------------------------------------
// absum_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module absum_out_reg
  import absum_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    advance_o,
  input  result_t result_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign advance_o   = valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

endmodule

@@ src/ab_boot_slot_update_manager_core.sv @@
// ----------------------------------------------------------------------------
// ab_boot_slot_update_manager_core
// A/B firmware slot metadata keeper with staged candidate and rollback.
// ----------------------------------------------------------------------------
// Each request (stage, boot attempt, confirm, restore) is taken into an input
// register, evaluated combinationally against the slot metadata and written to
// a result register together with the updated metadata, from which it drives
// the outputs. One request is accepted every cycle while the result side keeps
// up, the limit being the evaluation loop through the metadata registers. The
// user must write max_boot_attempts through cfg_we_i/cfg_wdata_i only while no
// request is in flight; the block itself does not enforce this.
module ab_boot_slot_update_manager_core
  import absum_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [AttemptWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic [SlotWidth-1:0]    slot_i,
  input  logic [VersionWidth-1:0] version_i,
  input  logic [VersionWidth-1:0] floor_version_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic                    rollback_o,
  output logic                    cur_active_slot_o,
  output logic [VersionWidth-1:0] cur_active_version_o,
  output logic [VersionWidth-1:0] cur_floor_version_o,
  output logic                    candidate_pending_o,
  output logic                    cur_pending_slot_o,
  output logic [VersionWidth-1:0] cur_pending_version_o,
  output logic [AttemptWidth-1:0] cur_attempts_o
);

  item_t   item_in;
  item_t   item_q;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t result_q;

  assign item_in.mode          = mode_e'(mode_i);
  assign item_in.slot          = slot_i;
  assign item_in.version       = version_i;
  assign item_in.floor_version = floor_version_i;

  absum_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .item_i    (item_in),
    .valid_o   (item_valid),
    .advance_i (advance),
    .item_o    (item_q)
  );

  absum_meta_core u_meta_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .advance_i  (advance),
    .item_i     (item_q),
    .result_o   (result)
  );

  absum_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (item_valid),
    .advance_o  (advance),
    .result_i   (result),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (result_q)
  );

  assign status_o              = result_q.status;
  assign rollback_o            = result_q.rollback;
  assign cur_active_slot_o     = result_q.meta.live_slot;
  assign cur_active_version_o  = result_q.meta.live_version;
  assign cur_floor_version_o   = result_q.meta.floor_version;
  assign candidate_pending_o   = result_q.meta.pending;
  assign cur_pending_slot_o    = result_q.meta.cand_slot;
  assign cur_pending_version_o = result_q.meta.cand_version;
  assign cur_attempts_o        = result_q.meta.attempts;

endmodule
